>>> rtl/mec_pkg.sv
package mec_pkg;

    localparam int KIND_W  = 3;
    localparam int BTN_W   = 3;
    localparam int MOD_W   = 4;
    localparam int STEP_W  = 2;
    localparam int COUNT_W = 2;
    localparam int CFG_W   = 16;
    localparam int NRES_W  = 2;

    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 32;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [CFG_W-1:0] CLICK_TIMEOUT_RST  = 16'd400;
    localparam logic [CFG_W-1:0] DCLICK_TIMEOUT_RST = 16'd500;

    localparam logic [STEP_W-1:0]  WHEEL_NONE = 2'b00;
    localparam logic [STEP_W-1:0]  WHEEL_POS  = 2'b01;
    localparam logic [STEP_W-1:0]  WHEEL_NEG  = 2'b11;
    localparam logic [COUNT_W-1:0] COUNT_NONE   = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_SINGLE = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_DOUBLE = 2'd2;

    localparam logic [NRES_W-1:0] NRES_NONE = 2'd0;
    localparam logic [NRES_W-1:0] NRES_ONE  = 2'd1;
    localparam logic [NRES_W-1:0] NRES_TWO  = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESSED  = 3'd0,
        KIND_RELEASED = 3'd1,
        KIND_MOVED    = 3'd2,
        KIND_DRAGGED  = 3'd3,
        KIND_WHEEL    = 3'd4,
        KIND_CLICKED  = 3'd5
    } kind_t;

    typedef enum logic [0:0] {
        REG_CLICK_TIMEOUT  = 1'b0,
        REG_DCLICK_TIMEOUT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] click_timeout;
        logic [CFG_W-1:0] dclick_timeout;
    } timeouts_t;

endpackage

>>> rtl/mouse_event_classifier.sv
// channel   | dir | ports          | contents
// s_axis    | in  | tvalid/tready  | tuser: event_kind; tdata: raw report
// m_axis    | out | tvalid/tready  | tuser: out_kind; tlast: last_of_run
// cfg       | in  | cfg_we         | cfg_index selects timeout register
//
// one request per cycle enters the input register; s_axis_tready drops only
// while a request is held and the queue has fewer than two free entries.
// the held request is classified once the queue has room and yields zero,
// one or two (with a click) results in a 4-entry result queue, which drains
// one result per cycle while m_axis_tready is high. reset is synchronous,
// active low, clears history and the queue, restores the default timeouts.
module mouse_event_classifier #(
    parameter int COORD_BITS = mec_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = mec_pkg::TIME_BITS_DEF,
    parameter int IN_DATA_W  = ((7 + 2 * COORD_BITS + TIME_BITS + 7) / 8) * 8,
    parameter int OUT_DATA_W = ((11 + 2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // button_code, modifier_keys, pos_x, pos_y, time_ms
    input  logic [IN_DATA_W-1:0]        s_axis_tdata,
    // event_kind
    input  logic [mec_pkg::KIND_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // out_button, out_modifiers, out_x, out_y, wheel_step, click_count
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    // out_kind
    output logic [mec_pkg::KIND_W-1:0]  m_axis_tuser,
    output logic                        m_axis_tlast,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [mec_pkg::CFG_W-1:0]   cfg_wdata
);
    import mec_pkg::*;

    localparam int ENTRY_W = KIND_W + 1 + OUT_DATA_W;
    localparam int X_LO    = BTN_W + MOD_W;
    localparam int Y_LO    = X_LO + COORD_BITS;
    localparam int T_LO    = Y_LO + COORD_BITS;

    timeouts_t             timeouts_reg;
    logic                  in_valid_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [BTN_W-1:0]      btn_reg;
    logic [MOD_W-1:0]      mods_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [TIME_BITS-1:0]  time_reg;

    logic                  space_ok;
    logic [NRES_W-1:0]     res_cnt;
    logic                  proc_fire;
    logic [ENTRY_W-1:0]    res0, res1, out_entry;

    assign proc_fire     = in_valid_reg && space_ok;
    assign s_axis_tready = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeouts_reg.click_timeout  <= CLICK_TIMEOUT_RST;
            timeouts_reg.dclick_timeout <= DCLICK_TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CLICK_TIMEOUT:  timeouts_reg.click_timeout  <= cfg_wdata;
                REG_DCLICK_TIMEOUT: timeouts_reg.dclick_timeout <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            kind_reg <= s_axis_tuser;
            btn_reg  <= s_axis_tdata[BTN_W-1:0];
            mods_reg <= s_axis_tdata[BTN_W +: MOD_W];
            x_reg    <= s_axis_tdata[X_LO +: COORD_BITS];
            y_reg    <= s_axis_tdata[Y_LO +: COORD_BITS];
            time_reg <= s_axis_tdata[T_LO +: TIME_BITS];
        end
    end

    mec_classify #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_classify (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .timeouts (timeouts_reg),
        .fire     (proc_fire),
        .kind_in  (kind_reg),
        .btn_in   (btn_reg),
        .mods_in  (mods_reg),
        .x_in     (x_reg),
        .y_in     (y_reg),
        .time_in  (time_reg),
        .res_cnt  (res_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    logic [NRES_W-1:0] push_cnt_gated;
    assign push_cnt_gated = proc_fire ? res_cnt : NRES_NONE;

    mec_out_fifo #(
        .ENTRY_W (ENTRY_W)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt_gated),
        .push0     (res0),
        .push1     (res1),
        .space_ok  (space_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_entry (out_entry)
    );

    assign m_axis_tdata = out_entry[OUT_DATA_W-1:0];
    assign m_axis_tlast = out_entry[OUT_DATA_W];
    assign m_axis_tuser = out_entry[ENTRY_W-1 -: KIND_W];

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proc_fire |=> in_valid_reg && $stable(time_reg) && $stable(kind_reg))
        else $error("held request lost while stalled");

endmodule

>>> rtl/mec_classify.sv
module mec_classify #(
    parameter int COORD_BITS = mec_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = mec_pkg::TIME_BITS_DEF,
    parameter int ENTRY_W    = mec_pkg::KIND_W + 1
                               + ((mec_pkg::BTN_W + mec_pkg::MOD_W + 2 * COORD_BITS
                                   + mec_pkg::STEP_W + mec_pkg::COUNT_W + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mec_pkg::timeouts_t       timeouts,
    input  logic                     fire,
    input  logic [mec_pkg::KIND_W-1:0] kind_in,
    input  logic [mec_pkg::BTN_W-1:0]  btn_in,
    input  logic [mec_pkg::MOD_W-1:0]  mods_in,
    input  logic [COORD_BITS-1:0]      x_in,
    input  logic [COORD_BITS-1:0]      y_in,
    input  logic [TIME_BITS-1:0]       time_in,
    output logic [mec_pkg::NRES_W-1:0] res_cnt,
    output logic [ENTRY_W-1:0]         res0,
    output logic [ENTRY_W-1:0]         res1
);
    import mec_pkg::*;

    localparam int DATA_BITS = BTN_W + MOD_W + 2 * COORD_BITS + STEP_W + COUNT_W;
    localparam int DATA_W    = ((DATA_BITS + 7) / 8) * 8;
    localparam int PAD_W     = DATA_W - DATA_BITS;

    kind_t                 prev_kind_reg;
    logic [BTN_W-1:0]      prev_btn_reg;
    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic [TIME_BITS-1:0]  press_time_reg, click_time_reg;

    kind_t                 kind_n, adj;
    logic                  is_wheel, repeat_hit, same_pos, drop, click, dbl;
    logic [STEP_W-1:0]     wheel;
    logic [COUNT_W-1:0]    count;
    logic [TIME_BITS-1:0]  held, since;

    always_comb begin
        kind_n = (kind_in > KIND_WHEEL) ? KIND_MOVED : kind_t'(kind_in);
        is_wheel = (kind_n == KIND_WHEEL);
        repeat_hit = ((prev_kind_reg == kind_n) && (prev_btn_reg == btn_in))
                     || (btn_in == '0);
        same_pos = (prev_x_reg == x_in) && (prev_y_reg == y_in);
        drop = !is_wheel && repeat_hit && same_pos;
        if (is_wheel) begin
            adj = KIND_WHEEL;
        end else if (repeat_hit) begin
            adj = ((kind_n == KIND_PRESSED) && (btn_in != '0)) ? KIND_DRAGGED : KIND_MOVED;
        end else begin
            adj = kind_n;
        end
        wheel = !is_wheel ? WHEEL_NONE : ((btn_in == '0) ? WHEEL_NEG : WHEEL_POS);
        held  = time_in - press_time_reg;
        since = time_in - click_time_reg;
        click = (adj == KIND_RELEASED) && (prev_btn_reg == btn_in)
                && (held < TIME_BITS'(timeouts.click_timeout));
        dbl   = since < TIME_BITS'(timeouts.dclick_timeout);
        count = dbl ? COUNT_DOUBLE : COUNT_SINGLE;
        if (drop) begin
            res_cnt = NRES_NONE;
        end else if (click) begin
            res_cnt = NRES_TWO;
        end else begin
            res_cnt = NRES_ONE;
        end
    end

    // entry: {kind, last, tdata}
    assign res0 = {adj, !click, {PAD_W{1'b0}}, COUNT_NONE, wheel, y_in, x_in, mods_in, btn_in};
    assign res1 = {KIND_CLICKED, 1'b1, {PAD_W{1'b0}}, count, WHEEL_NONE,
                   y_in, x_in, mods_in, btn_in};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_kind_reg  <= KIND_PRESSED;
            prev_btn_reg   <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            press_time_reg <= '0;
            click_time_reg <= '0;
        end else if (fire && !drop) begin
            prev_kind_reg <= kind_n;
            prev_btn_reg  <= btn_in;
            prev_x_reg    <= x_in;
            prev_y_reg    <= y_in;
            if (adj == KIND_PRESSED) begin
                press_time_reg <= time_in;
            end
            if (click) begin
                click_time_reg <= dbl ? '0 : time_in;
            end
        end
    end

    a_double_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (res_cnt == NRES_TWO) && dbl |=> (click_time_reg == '0))
        else $error("double click did not clear stored click time");

endmodule

>>> rtl/mec_out_fifo.sv
module mec_out_fifo #(
    parameter int ENTRY_W = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [mec_pkg::NRES_W-1:0] push_cnt,
    input  logic [ENTRY_W-1:0]   push0,
    input  logic [ENTRY_W-1:0]   push1,
    output logic                 space_ok,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ENTRY_W-1:0]   out_entry
);
    import mec_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [ENTRY_W-1:0] mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_entry = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign space_ok  = (count_reg <= CNT_W'(FIFO_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != NRES_NONE) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == NRES_TWO) begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_space: assert property (@(posedge aclk) disable iff (!aresetn)
        !space_ok |-> (push_cnt == NRES_NONE))
        else $error("results pushed without room");

endmodule
